### rtl/rrte_pkg.sv
// ----------------------------------------------------------------------------
// rrte_pkg
// types and constants shared by the route table engine
// ----------------------------------------------------------------------------
package rrte_pkg;

    localparam logic [1:0] OP_UPDATE  = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_EXPORT  = 2'd2;
    localparam logic [1:0] OP_INSTALL = 2'd3;

    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_CHANGED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [2:0] CFG_TIMEOUT = 3'd4;
    localparam logic [2:0] CFG_HOLD    = 3'd5;

    localparam logic [4:0] METRIC_INF = 5'd16;

    // entry record kept in the table memory
    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [31:0] source;
        logic [1:0]  port;
        logic [4:0]  metric;
        logic [15:0] tag;
        logic [31:0] refresh;
        logic [31:0] hold;
    } route_t;

    localparam int ROUTE_W = $bits(route_t);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_UPD_RD,
        S_UPD_WR,
        S_TICK_RD,
        S_TICK_CHK,
        S_INS_WR,
        S_EXP_RD,
        S_EXP_OUT,
        S_DONE
    } state_t;

endpackage

### rtl/rip_route_table_engine.sv
// ----------------------------------------------------------------------------
// rip_route_table_engine
// distance-vector route table with update, tick, export and install
// ----------------------------------------------------------------------------
// one beat in on the input channel gives one beat out on the result channel.
// in_stall is high while an item is at work or its result still waits.
// update and install scan the table slot by slot, a read state then a check
// state per slot, through one memory port and one compare unit, then write
// at most one slot. an update stops at its matching slot or is dropped before
// the scan.
// tick visits each slot twice (timeout pass then hold pass). export reads
// the one slot named by slot.
// the result is held in output registers while out_stall is high; the next
// item is taken once it has been delivered.
// reset clears used and valid bits, sets the clock to one and the costs and
// timers to their defaults; memory contents are not cleared.
// configuration writes are taken whenever cfg_we is high.
// ----------------------------------------------------------------------------
module rip_route_table_engine #(
    parameter int TABLE_DEPTH = 64,
    parameter int NUM_PORTS   = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [31:0] dest_ip,
    input  logic [31:0] net_mask,
    input  logic [7:0]  metric_in,
    input  logic [15:0] tag_in,
    input  logic [31:0] neighbour_ip,
    input  logic [1:0]  port,
    input  logic [5:0]  slot,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] out_dest,
    output logic [31:0] out_mask,
    output logic [4:0]  out_metric,
    output logic [15:0] out_tag,
    output logic        out_occupied
);

    localparam int AW = $clog2(TABLE_DEPTH);

    rrte_pkg::state_t state_reg, state_next;

    logic [3:0]  cost_reg [4];
    logic [15:0] timeout_reg, hold_reg;
    logic [31:0] now_reg, now_next;
    logic [TABLE_DEPTH-1:0] used_reg, used_next, valid_reg, valid_next;

    logic [1:0]  op_reg;
    logic [31:0] d_reg, m_reg, nb_reg;
    logic [7:0]  mi_reg;
    logic [15:0] tg_reg;
    logic [1:0]  p_reg;
    logic [5:0]  s_reg;
    logic        pass_reg, pass_next;
    logic [AW:0] idx_reg, idx_next;
    logic [AW-1:0] hit_reg, hit_next;
    logic        found_reg, found_next;
    logic        changed_reg, changed_next;
    logic        ok_p;

    logic [1:0]  status_reg, status_next;
    logic [31:0] od_reg, od_next, om_reg, om_next;
    logic [4:0]  oe_reg, oe_next;
    logic [15:0] ot_reg, ot_next;
    logic        oo_reg, oo_next;

    logic          we;
    logic [AW-1:0] addr;
    rrte_pkg::route_t wr, rd;
    logic [rrte_pkg::ROUTE_W-1:0] rdata;
    logic [4:0]  cost, nm;
    logic [5:0]  nm_sum;
    logic        accept;
    logic [AW-1:0] cur;

    assign rd = rrte_pkg::route_t'(rdata);
    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != rrte_pkg::S_IDLE);
    assign out_valid = (state_reg == rrte_pkg::S_DONE);
    assign status = status_reg;
    assign out_dest = od_reg;
    assign out_mask = om_reg;
    assign out_metric = oe_reg;
    assign out_tag = ot_reg;
    assign out_occupied = oo_reg;
    assign cur = idx_reg[AW-1:0];
    assign ok_p = ({30'd0, p_reg} < 32'(NUM_PORTS));
    assign cost = (cost_reg[p_reg] == 4'd0) ? 5'd1 : {1'b0, cost_reg[p_reg]};
    assign nm_sum = {1'b0, mi_reg[4:0]} + {1'b0, cost};
    assign nm = nm_sum[4:0];

    rrte_ram #(.WIDTH(rrte_pkg::ROUTE_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk  (clk),
        .we   (we),
        .addr (addr),
        .wdata(wr),
        .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rrte_pkg::S_IDLE;
            cost_reg    <= '{4'd1, 4'd1, 4'd1, 4'd1};
            timeout_reg <= 16'd180;
            hold_reg    <= 16'd120;
            now_reg     <= 32'd1;
            used_reg    <= '0;
            valid_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            now_reg   <= now_next;
            used_reg  <= used_next;
            valid_reg <= valid_next;
            if (cfg_we)
            begin
                if (cfg_index < 3'd4)
                begin
                    cost_reg[cfg_index[1:0]] <= cfg_wdata[3:0];
                end
                else if (cfg_index == rrte_pkg::CFG_TIMEOUT)
                begin
                    timeout_reg <= cfg_wdata;
                end
                else if (cfg_index == rrte_pkg::CFG_HOLD)
                begin
                    hold_reg <= cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= opcode;
            d_reg  <= dest_ip;
            m_reg  <= net_mask;
            mi_reg <= metric_in;
            tg_reg <= tag_in;
            nb_reg <= neighbour_ip;
            p_reg  <= port;
            s_reg  <= slot;
        end
        pass_reg    <= pass_next;
        idx_reg     <= idx_next;
        hit_reg     <= hit_next;
        found_reg   <= found_next;
        changed_reg <= changed_next;
        status_reg  <= status_next;
        od_reg      <= od_next;
        om_reg      <= om_next;
        oe_reg      <= oe_next;
        ot_reg      <= ot_next;
        oo_reg      <= oo_next;
    end

    always_comb
    begin
        logic match, last, infin, dbl;
        state_next   = state_reg;
        now_next     = now_reg;
        used_next    = used_reg;
        valid_next   = valid_reg;
        pass_next    = pass_reg;
        idx_next     = idx_reg;
        hit_next     = hit_reg;
        found_next   = found_reg;
        changed_next = changed_reg;
        status_next  = status_reg;
        od_next      = od_reg;
        om_next      = om_reg;
        oe_next      = oe_reg;
        ot_next      = ot_reg;
        oo_next      = oo_reg;
        we           = 1'b0;
        addr         = cur;
        wr           = rd;
        infin        = (mi_reg >= 8'd16);
        dbl          = (op_reg == rrte_pkg::OP_INSTALL);
        last         = (idx_reg == (AW+1)'(TABLE_DEPTH - 1));
        match        = used_reg[cur] && rd.dest == d_reg && rd.mask == m_reg
                       && (!infin || dbl || op_reg != rrte_pkg::OP_UPDATE
                           || rd.source == nb_reg);
        unique case (state_reg)
            rrte_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    idx_next = '0;
                    found_next = 1'b0;
                    changed_next = 1'b0;
                    pass_next = 1'b0;
                    status_next = rrte_pkg::ST_NONE;
                    od_next = '0;
                    om_next = '0;
                    oe_next = '0;
                    ot_next = '0;
                    oo_next = 1'b0;
                    unique case (opcode)
                        rrte_pkg::OP_TICK:
                        begin
                            now_next = now_reg + 32'd1;
                            state_next = rrte_pkg::S_TICK_RD;
                        end
                        rrte_pkg::OP_EXPORT:
                            state_next = rrte_pkg::S_EXP_RD;
                        rrte_pkg::OP_INSTALL:
                        begin
                            state_next = rrte_pkg::S_SCAN_RD;
                        end
                        default:
                            state_next = rrte_pkg::S_SCAN_RD;
                    endcase
                end
            end
            rrte_pkg::S_SCAN_RD:
            begin
                if (!ok_p || (op_reg == rrte_pkg::OP_UPDATE && !infin
                              && nm_sum >= 6'd16))
                begin
                    state_next = rrte_pkg::S_DONE;
                end
                else
                begin
                    state_next = rrte_pkg::S_SCAN_CHK;
                end
            end
            rrte_pkg::S_SCAN_CHK:
            begin
                if (dbl)
                begin
                    if (used_reg[cur] && rd.dest == (d_reg & m_reg)
                        && rd.mask == m_reg)
                    begin
                        used_next[cur] = 1'b0;
                    end
                    if (!used_next[cur] && !found_reg)
                    begin
                        found_next = 1'b1;
                        hit_next = cur;
                    end
                    if (last)
                    begin
                        state_next = rrte_pkg::S_INS_WR;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        state_next = rrte_pkg::S_SCAN_RD;
                    end
                end
                else if (match)
                begin
                    hit_next = cur;
                    found_next = 1'b1;
                    state_next = rrte_pkg::S_UPD_WR;
                end
                else
                begin
                    if (!used_reg[cur] && !pass_reg)
                    begin
                        pass_next = 1'b1;
                        hit_next = cur;
                    end
                    if (last)
                    begin
                        if (infin)
                        begin
                            state_next = rrte_pkg::S_DONE;
                        end
                        else
                        begin
                            found_next = pass_next;
                            state_next = rrte_pkg::S_INS_WR;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        state_next = rrte_pkg::S_SCAN_RD;
                    end
                end
            end
            rrte_pkg::S_UPD_WR:
            begin
                we = 1'b1;
                addr = hit_reg;
                state_next = rrte_pkg::S_DONE;
                if (infin)
                begin
                    valid_next[hit_reg] = 1'b0;
                    wr.metric = rrte_pkg::METRIC_INF;
                    wr.hold = now_reg;
                    status_next = rrte_pkg::ST_CHANGED;
                end
                else if (rd.source == nb_reg)
                begin
                    wr.refresh = now_reg;
                    if (rd.metric != nm)
                    begin
                        wr.metric = nm;
                        wr.gateway = nb_reg;
                        wr.tag = tg_reg;
                        if (!valid_reg[hit_reg])
                        begin
                            valid_next[hit_reg] = 1'b1;
                            wr.hold = '0;
                        end
                        status_next = rrte_pkg::ST_CHANGED;
                    end
                end
                else if (nm < rd.metric)
                begin
                    wr.metric = nm;
                    wr.gateway = nb_reg;
                    wr.source = nb_reg;
                    wr.refresh = now_reg;
                    wr.tag = tg_reg;
                    wr.port = p_reg;
                    if (!valid_reg[hit_reg])
                    begin
                        valid_next[hit_reg] = 1'b1;
                        wr.hold = '0;
                    end
                    status_next = rrte_pkg::ST_CHANGED;
                end
                else if (nm == rd.metric && rd.gateway == nb_reg)
                begin
                    wr.refresh = now_reg;
                end
            end
            rrte_pkg::S_INS_WR:
            begin
                addr = hit_reg;
                wr.dest = dbl ? (d_reg & m_reg) : d_reg;
                wr.mask = m_reg;
                wr.gateway = dbl ? 32'd0 : nb_reg;
                wr.source = dbl ? 32'd0 : nb_reg;
                wr.port = p_reg;
                wr.metric = dbl ? cost : nm;
                wr.tag = dbl ? 16'd0 : tg_reg;
                wr.refresh = now_reg;
                wr.hold = '0;
                state_next = rrte_pkg::S_DONE;
                if (found_reg)
                begin
                    we = 1'b1;
                    used_next[hit_reg] = 1'b1;
                    valid_next[hit_reg] = 1'b1;
                    status_next = rrte_pkg::ST_CHANGED;
                end
                else
                begin
                    status_next = rrte_pkg::ST_FULL;
                end
            end
            rrte_pkg::S_TICK_RD:
                state_next = rrte_pkg::S_TICK_CHK;
            rrte_pkg::S_TICK_CHK:
            begin
                if (!pass_reg)
                begin
                    if (used_reg[cur] && rd.source != 32'd0 && valid_reg[cur]
                        && (now_reg - rd.refresh) >= {16'd0, timeout_reg})
                    begin
                        we = 1'b1;
                        valid_next[cur] = 1'b0;
                        wr.metric = rrte_pkg::METRIC_INF;
                        wr.hold = now_reg;
                        changed_next = 1'b1;
                    end
                end
                else if (used_reg[cur] && !valid_reg[cur] && rd.hold != 32'd0
                         && (now_reg - rd.hold) >= {16'd0, hold_reg})
                begin
                    used_next[cur] = 1'b0;
                    changed_next = 1'b1;
                end
                if (last)
                begin
                    idx_next = '0;
                    if (pass_reg)
                    begin
                        status_next = {1'b0, changed_next};
                        state_next = rrte_pkg::S_DONE;
                    end
                    else
                    begin
                        pass_next = 1'b1;
                        state_next = rrte_pkg::S_TICK_RD;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = rrte_pkg::S_TICK_RD;
                end
            end
            rrte_pkg::S_EXP_RD:
            begin
                addr = AW'(s_reg);
                state_next = rrte_pkg::S_EXP_OUT;
            end
            rrte_pkg::S_EXP_OUT:
            begin
                addr = AW'(s_reg);
                state_next = rrte_pkg::S_DONE;
                if ({26'd0, s_reg} < 32'(TABLE_DEPTH) && used_reg[AW'(s_reg)])
                begin
                    od_next = rd.dest;
                    om_next = rd.mask;
                    ot_next = rd.tag;
                    oo_next = 1'b1;
                    if (!valid_reg[AW'(s_reg)]
                        || (rd.source != 32'd0 && rd.port == p_reg))
                    begin
                        oe_next = rrte_pkg::METRIC_INF;
                    end
                    else if (rd.metric > rrte_pkg::METRIC_INF)
                    begin
                        oe_next = rrte_pkg::METRIC_INF;
                    end
                    else if (rd.metric == 5'd0)
                    begin
                        oe_next = 5'd1;
                    end
                    else
                    begin
                        oe_next = rd.metric;
                    end
                end
            end
            rrte_pkg::S_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = rrte_pkg::S_IDLE;
                end
            end
            default:
                state_next = rrte_pkg::S_IDLE;
        endcase
    end

endmodule

### rtl/rrte_ram.sv
// ----------------------------------------------------------------------------
// rrte_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
module rrte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/rrte_checker.sv
// ----------------------------------------------------------------------------
// rrte_checker
// port level checks for the route table engine
// ----------------------------------------------------------------------------
module rrte_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] status,
    input logic       out_occupied,
    input logic [4:0] out_metric
);

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("not busy after accepted beat");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status)))
        else $error("stalled result changed");

    a_metric: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_occupied) |-> (out_metric != 5'd0 && out_metric <= 5'd16))
        else $error("exported metric out of range");

endmodule

bind rip_route_table_engine rrte_checker u_rrte_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .out_occupied(out_occupied),
    .out_metric  (out_metric)
);
